// ===== hdl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// Split alignment classifier package
// Class codes and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned MASK_W = 17;
    localparam int unsigned CLS_W  = 2;
    localparam int unsigned SLOT_W = 4;
    localparam logic [MASK_W-1:0] MASK_RESET = 17'd32768;

    localparam logic [CLS_W-1:0] CLS_PRIMARY       = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SUPPLEMENTARY = 2'd1;
    localparam logic [CLS_W-1:0] CLS_SECONDARY     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the input beat and handle a read change
        logic decide;    // settle primary and empty-span chains
        logic rd;        // read the store at the scan index
        logic ev;        // fold the read entry into the coverage sweep
        logic pass_end;  // close one sweep pass
        logic mul;       // form both sides of the ratio test
        logic cmp;       // compare, classify and store
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quick;     // chain is settled without a sweep
        logic last;      // scan index is at the last stored entry
        logic more;      // another sweep pass is needed
    } t_sts;

endpackage

// ===== hdl/sac_if.sv =====
// ----------------------------------------------------------------------------
// Split alignment classifier channels
// Chain input, result output and mask write channels with valid and ready.
// ----------------------------------------------------------------------------
interface sac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_id;
    logic [31:0] span_start;
    logic [31:0] query_end;
    modport source (output valid, output read_id, output span_start, output query_end,
                    input ready);
    modport sink   (input valid, input read_id, input span_start, input query_end,
                    output ready);
endinterface

interface sac_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  chain_class;
    logic [3:0]  parent_slot;
    logic [31:0] covered_length;
    logic        store_overflow;
    modport source (output valid, output chain_class, output parent_slot,
                    output covered_length, output store_overflow, input ready);
    modport sink   (input valid, input chain_class, input parent_slot,
                    input covered_length, input store_overflow, output ready);
endinterface

interface sac_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sac_datapath.sv =====
// ----------------------------------------------------------------------------
// Split alignment classifier datapath
// Span store, coverage sweep, best-overlap search, ratio test and result.
// ----------------------------------------------------------------------------
module sac_datapath #(
    parameter int unsigned MAX_PRIMARIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sac_pkg::t_cmd                i_cmd,
    output sac_pkg::t_sts                o_sts,
    input  logic [31:0]                  i_read_id,
    input  logic [31:0]                  i_span_start,
    input  logic [31:0]                  i_query_end,
    input  logic                         i_cfg_we,
    input  logic [16:0]                  i_cfg_data,
    output logic [1:0]                   o_chain_class,
    output logic [3:0]                   o_parent_slot,
    output logic [31:0]                  o_covered_length,
    output logic                         o_store_overflow
);
    import sac_pkg::*;

    localparam int unsigned IDX_W = (MAX_PRIMARIES > 1) ? $clog2(MAX_PRIMARIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_PRIMARIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PRIMARIES);

    // Span store.
    logic [POS_W-1:0] mem_s [MAX_PRIMARIES];
    logic [POS_W-1:0] mem_e [MAX_PRIMARIES];

    logic [ID_W-1:0]   r_rid;
    logic              r_open;
    logic [CNT_W-1:0]  r_count;
    logic [MASK_W-1:0] r_mask;
    logic [POS_W-1:0]  r_s, r_e, r_cur, r_total, r_next, r_best;
    logic [POS_W-1:0]  r_rd_s, r_rd_e;
    logic              r_changed, r_has_next, r_first_pass;
    logic [IDX_W-1:0]  r_idx, r_parent;
    logic [47:0]       r_lhs;
    logic [48:0]       r_rhs;
    logic [CLS_W-1:0]  r_res_cls;
    logic [IDX_W-1:0]  r_res_parent;
    logic [POS_W-1:0]  r_res_cov;
    logic              r_res_ovf;

    logic              new_group;
    logic              ov, sup, we;
    logic [POS_W-1:0]  cx, cy, ol;
    logic [IDX_W-1:0]  we_addr;

    assign new_group = !r_open || (i_read_id != r_rid);

    // Clip the read entry to the chain span.
    always_comb begin
        ov = (r_rd_e > r_s) && (r_rd_s < r_e);
        cx = (r_rd_s < r_s) ? r_s : r_rd_s;
        cy = (r_rd_e > r_e) ? r_e : r_rd_e;
        ol = cy - cx;
        sup = ({1'b0, r_lhs} <= r_rhs);
    end

    // Store writes: slot 0 for a primary, the next free slot for a supplementary.
    always_comb begin
        we      = 1'b0;
        we_addr = '0;
        if (i_cmd.decide && r_count == '0) begin
            we = 1'b1;
        end else if (i_cmd.cmp && sup && r_count < CNT_MAX) begin
            we      = 1'b1;
            we_addr = r_count[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_s[we_addr] <= r_s;
            mem_e[we_addr] <= r_e;
        end
        if (i_cmd.rd) begin
            r_rd_s <= mem_s[r_idx];
            r_rd_e <= mem_e[r_idx];
        end
    end

    assign o_sts.quick = (r_count == '0) || (r_e == r_s);
    assign o_sts.last  = ({1'b0, r_idx} + (IDX_W+1)'(1)) == (IDX_W+1)'(r_count);
    assign o_sts.more  = r_changed || r_has_next;

    // Control state of the group and the mask register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_rid   <= '0;
            r_count <= '0;
            r_mask  <= MASK_RESET;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            if (i_cmd.accept && new_group) begin
                r_open  <= 1'b1;
                r_rid   <= i_read_id;
                r_count <= '0;
            end else if (we) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Sweep and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s <= i_span_start;
            r_e <= (i_query_end < i_span_start) ? i_span_start : i_query_end;
        end
        if (i_cmd.decide) begin
            r_cur        <= r_s;
            r_total      <= '0;
            r_idx        <= '0;
            r_changed    <= 1'b0;
            r_has_next   <= 1'b0;
            r_best       <= '0;
            r_parent     <= '0;
            r_first_pass <= 1'b1;
            r_res_cls    <= (r_count == '0) ? CLS_PRIMARY : CLS_SECONDARY;
            r_res_parent <= '0;
            r_res_cov    <= '0;
            r_res_ovf    <= 1'b0;
        end
        if (i_cmd.ev) begin
            if (ov) begin
                if (cx <= r_cur && cy > r_cur) begin
                    r_total   <= r_total + (cy - r_cur);
                    r_cur     <= cy;
                    r_changed <= 1'b1;
                end else if (cx > r_cur && (!r_has_next || cx < r_next)) begin
                    r_next     <= cx;
                    r_has_next <= 1'b1;
                end
                if (r_first_pass && ol > r_best) begin
                    r_best   <= ol;
                    r_parent <= r_idx;
                end
            end
            if (!o_sts.last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
        if (i_cmd.pass_end) begin
            // With no growth in the pass, skip the uncovered gap.
            if (!r_changed && r_has_next) begin
                r_cur <= r_next;
            end
            r_changed    <= 1'b0;
            r_has_next   <= 1'b0;
            r_idx        <= '0;
            r_first_pass <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_lhs <= {r_total, 16'd0};
            r_rhs <= r_mask * (r_e - r_s);
        end
        if (i_cmd.cmp) begin
            r_res_cov <= r_total;
            if (sup) begin
                r_res_cls    <= CLS_SUPPLEMENTARY;
                r_res_parent <= '0;
                r_res_ovf    <= !(r_count < CNT_MAX);
            end else begin
                r_res_cls    <= CLS_SECONDARY;
                r_res_parent <= r_parent;
                r_res_ovf    <= 1'b0;
            end
        end
        if (i_cmd.load_out) begin
            o_chain_class    <= r_res_cls;
            o_parent_slot    <= SLOT_W'(r_res_parent);
            o_covered_length <= r_res_cov;
            o_store_overflow <= r_res_ovf;
        end
    end

`ifndef SYNTHESIS
    // The store never holds more spans than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX) else $error("span count beyond store depth");
    // The sweep front stays inside the chain span while it scans.
    a_cur_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ev |-> (r_cur >= r_s && r_cur <= r_e)) else $error("sweep front left span");
    // Covered length never exceeds the span length at the ratio test.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> (r_total <= r_e - r_s)) else $error("coverage beyond span");
    // An overflow is only reported for a supplementary chain.
    a_overflow_sup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_res_ovf |-> r_res_cls == CLS_SUPPLEMENTARY)
        else $error("overflow on a non-supplementary chain");
`endif

endmodule

// ===== hdl/sac_ctrl.sv =====
// ----------------------------------------------------------------------------
// Split alignment classifier controller
// Sequences accept, store sweep passes, ratio test and result hand-off.
// ----------------------------------------------------------------------------
module sac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  sac_pkg::t_sts i_sts,
    output sac_pkg::t_cmd o_cmd
);
    import sac_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_RD, S_EV, S_PASS, S_MUL, S_CMP, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.quick ? S_OUT : S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV: begin
                o_cmd.ev = 1'b1;
                n_state  = i_sts.last ? S_PASS : S_RD;
            end
            S_PASS: begin
                o_cmd.pass_end = 1'b1;
                n_state        = i_sts.more ? S_RD : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // A result is loaded only into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free) else $error("result overwrote pending beat");
    // Every accepted beat is followed by the decision step.
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.decide) else $error("decision step skipped");
    // A loaded result shows as valid in the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid) else $error("loaded result not valid");
`endif

endmodule

// ===== hdl/split_alignment_classifier.sv =====
// ----------------------------------------------------------------------------
// Split alignment classifier
// Classifies score-ordered chains as primary, supplementary or secondary.
// ----------------------------------------------------------------------------
// One chain is handled at a time. A primary or empty-span chain goes from
// accept through the decide step straight to the result. Any other chain
// sweeps the stored spans of its read from a single-port store, with a read
// and an evaluation step per stored span and pass and a closing step per
// pass, at most 2n+1 passes for n stored spans, then the ratio test and the
// compare step. The mask register is written on its own channel, which is
// always ready; write it only while no chain is in flight.
module split_alignment_classifier #(
    parameter int unsigned MAX_PRIMARIES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sac_in_if.sink   i_in,
    sac_out_if.source o_out,
    sac_cfg_if.sink  i_cfg
);
    import sac_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign i_cfg.ready = 1'b1;

    sac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sac_datapath #(.MAX_PRIMARIES(MAX_PRIMARIES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_read_id        (i_in.read_id),
        .i_span_start     (i_in.span_start),
        .i_query_end      (i_in.query_end),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_data       (i_cfg.data),
        .o_chain_class    (o_out.chain_class),
        .o_parent_slot    (o_out.parent_slot),
        .o_covered_length (o_out.covered_length),
        .o_store_overflow (o_out.store_overflow)
    );

endmodule
